/* hw/rtl/sha256_pkg.sv */
// types, constants and round functions shared by the sha-256 hash engine
`timescale 1ns / 1ps

package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_state_t;
    typedef logic [15:0][31:0] block_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_COMPRESS,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [6:0] LEN_POS     = 7'd56;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [3:0] MAX_BYTES   = 4'd8;
    localparam logic [2:0] LAST_INDEX  = 3'd7;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    localparam word_t HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int r);
        return word_t'((x >> r) | (x << (32 - r)));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* hw/rtl/sha256_core.sv */
// sha-256 compression unit: one round per cycle with a rolling 16-word schedule
`timescale 1ns / 1ps

module sha256_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::core_ctrl_t ctrl,
    input  sha256_pkg::block_t     block,
    output logic                   done,
    output sha256_pkg::hash_state_t hash
);

    sha256_pkg::hash_state_t h_reg;
    sha256_pkg::hash_state_t v_reg;
    sha256_pkg::hash_state_t v_next;
    sha256_pkg::word_t       w_reg [16];
    sha256_pkg::word_t       w_new;
    sha256_pkg::word_t       t1;
    sha256_pkg::word_t       t2;
    logic [5:0]              round_reg;
    logic                    busy_reg;
    logic                    fin_reg;

    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
        w_new = w_reg[0] + sha256_pkg::small_sigma0(w_reg[1]) + w_reg[9]
              + sha256_pkg::small_sigma1(w_reg[14]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::HASH_INIT[i];
            end
        end
        else
        begin
            if (ctrl.init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha256_pkg::HASH_INIT[i];
                end
            end
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == sha256_pkg::LAST_ROUND)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg)
            begin
                fin_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            v_reg <= h_reg;
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[15 - i];
            end
        end
        else if (busy_reg)
        begin
            v_reg <= v_next;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign done = fin_reg;
    assign hash = h_reg;

endmodule

/* hw/rtl/sha256_hash.sv */
// sha-256 hash engine top level: byte packing, padding sequencer and digest output
`timescale 1ns / 1ps

// Streaming SHA-256. Each input transaction carries up to eight message bytes (first
// byte in bits 63..56, byte_count above 8 taken as 8) and a last_word flag; a message
// ends with a last_word transaction, possibly with byte_count 0. The block accepts one
// transaction at a time: an item that does not complete a 64-byte block is accepted and
// then merged into the block shift register, the merge step also loading the round
// unit when the block fills; an item that completes a block then waits for the shared
// round unit (64 rounds at one round per cycle, then a fold into the hash) and resumes
// merging its remaining bytes, so no new item is taken before the last one is through.
// A last item then adds the padding steps (at most 8 bytes shifted in per cycle), one
// or two compressions, and eight digest transactions h0 first, digest_last on index 7,
// after which the engine restarts.
module sha256_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        message_valid,
    output logic        message_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    sha256_pkg::state_t      state_reg;
    sha256_pkg::state_t      state_next;
    sha256_pkg::state_t      ret_reg;
    sha256_pkg::state_t      ret_next;
    logic [6:0]              fill_reg;
    logic [6:0]              fill_next;
    logic [6:0]              fill_sum;
    logic [6:0]              space;
    logic [6:0]              gap;
    logic [63:0]             bitlen_reg;
    logic [63:0]             bitlen_next;
    logic [63:0]             hold_word_reg;
    logic [63:0]             hold_word_next;
    logic [3:0]              hold_cnt_reg;
    logic [3:0]              hold_cnt_next;
    logic                    hold_last_reg;
    logic                    hold_last_next;
    logic [2:0]              idx_reg;
    logic [2:0]              idx_next;
    logic [3:0]              cnt_sat;
    logic [3:0]              push_n;
    logic [63:0]             push_data;
    logic [511:0]            buf_reg;
    logic [511:0]            buf_next;
    sha256_pkg::core_ctrl_t  core_ctrl;
    logic                    core_done;
    sha256_pkg::hash_state_t core_hash;

    sha256_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .block (sha256_pkg::block_t'(buf_next)),
        .done  (core_done),
        .hash  (core_hash)
    );

    assign cnt_sat = (byte_count > sha256_pkg::MAX_BYTES) ? sha256_pkg::MAX_BYTES : byte_count;
    assign space   = sha256_pkg::BLOCK_BYTES - fill_reg;
    assign gap     = ((fill_reg > sha256_pkg::LEN_POS) ? sha256_pkg::BLOCK_BYTES
                                                       : sha256_pkg::LEN_POS) - fill_reg;

    // bytes shifted into the block this cycle
    always_comb
    begin
        push_n    = '0;
        push_data = hold_word_reg;
        case (state_reg)
            sha256_pkg::ST_MERGE:
            begin
                push_n = ({3'b000, hold_cnt_reg} <= space) ? hold_cnt_reg : space[3:0];
            end
            sha256_pkg::ST_PAD_MARK:
            begin
                push_n    = 4'd1;
                push_data = {sha256_pkg::PAD_MARK, 56'b0};
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                push_n    = (gap > {3'b000, sha256_pkg::MAX_BYTES}) ? sha256_pkg::MAX_BYTES
                                                                    : gap[3:0];
                push_data = '0;
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                push_n    = sha256_pkg::MAX_BYTES;
                push_data = bitlen_reg;
            end
            default:
            begin
                push_n = '0;
            end
        endcase
    end

    assign fill_sum = fill_reg + {3'b000, push_n};
    assign buf_next = (buf_reg << {push_n, 3'b000})
                    | ({448'b0, push_data} >> (7'd64 - {push_n, 3'b000}));

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        hold_word_next = hold_word_reg;
        hold_cnt_next  = hold_cnt_reg;
        hold_last_next = hold_last_reg;
        idx_next       = idx_reg;
        core_ctrl      = '0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (message_valid)
                begin
                    hold_word_next = message_word;
                    hold_cnt_next  = cnt_sat;
                    hold_last_next = last_word;
                    bitlen_next    = bitlen_reg + {57'b0, cnt_sat, 3'b000};
                    state_next     = sha256_pkg::ST_MERGE;
                end
            end
            sha256_pkg::ST_MERGE:
            begin
                hold_word_next = hold_word_reg << {push_n, 3'b000};
                hold_cnt_next  = hold_cnt_reg - push_n;
                if (fill_sum == sha256_pkg::BLOCK_BYTES)
                begin
                    fill_next       = '0;
                    core_ctrl.start = 1'b1;
                    ret_next        = sha256_pkg::ST_MERGE;
                    state_next      = sha256_pkg::ST_COMPRESS;
                end
                else
                begin
                    fill_next  = fill_sum;
                    state_next = hold_last_reg ? sha256_pkg::ST_PAD_MARK : sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_COMPRESS:
            begin
                if (core_done)
                begin
                    state_next = ret_reg;
                end
            end
            sha256_pkg::ST_PAD_MARK, sha256_pkg::ST_PAD_ZERO:
            begin
                if (fill_sum == sha256_pkg::BLOCK_BYTES)
                begin
                    fill_next       = '0;
                    core_ctrl.start = 1'b1;
                    ret_next        = sha256_pkg::ST_PAD_ZERO;
                    state_next      = sha256_pkg::ST_COMPRESS;
                end
                else
                begin
                    fill_next = fill_sum;
                    if (fill_sum == sha256_pkg::LEN_POS)
                    begin
                        state_next = sha256_pkg::ST_PAD_LEN;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_PAD_ZERO;
                    end
                end
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                fill_next       = '0;
                core_ctrl.start = 1'b1;
                ret_next        = sha256_pkg::ST_OUTPUT;
                state_next      = sha256_pkg::ST_COMPRESS;
            end
            sha256_pkg::ST_OUTPUT:
            begin
                if (digest_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::LAST_INDEX)
                    begin
                        core_ctrl.init = 1'b1;
                        bitlen_next    = '0;
                        fill_next      = '0;
                        state_next     = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            ret_reg    <= sha256_pkg::ST_IDLE;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        hold_word_reg <= hold_word_next;
        hold_cnt_reg  <= hold_cnt_next;
        hold_last_reg <= hold_last_next;
    end

    assign message_ready = (state_reg == sha256_pkg::ST_IDLE);
    assign digest_valid  = (state_reg == sha256_pkg::ST_OUTPUT);
    assign digest_word   = core_hash[idx_reg];
    assign digest_index  = idx_reg;
    assign digest_last   = (idx_reg == sha256_pkg::LAST_INDEX);

endmodule
